@@ rtl/srw_pkg.sv @@
// Shared sizes and the key entry type for the w-coordinate row sorter.
package srw_pkg;

    // Store depth and coordinate width
    localparam int MAX_ROWS   = 64;
    localparam int COORD_BITS = 32;

    // Derived widths
    localparam int IDX_W      = $clog2(MAX_ROWS);
    localparam int CNT_W      = $clog2(MAX_ROWS + 1);
    localparam int ROW_IDX_W  = 6;
    localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * COORD_BITS + ROW_IDX_W + 7) / 8) * 8;
    localparam int UV_W       = 2 * COORD_BITS;
    localparam int KEY_ROW_W  = COORD_BITS + IDX_W;

    // One entry of the key store: sort key and arrival slot
    typedef struct packed {
        logic [COORD_BITS-1:0] w;
        logic [IDX_W-1:0]      idx;
    } t_key_row;

endpackage

@@ rtl/srw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
module srw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sort_rows_by_w_coordinate.sv @@
// Buffers one time step of u/v/w rows and re-emits them in arrival order or sorted by w.
// Rows are taken one per cycle into two RAMs (u/v payload, and w key with arrival slot) until
// a word with tlast closes the time step. The input then stays not ready until the last stored
// row has been moved into the output register. Rows past MAX_ROWS are dropped and flag overflow
// on all results of that step. In sort mode an exchange sort runs on the key RAM with one signed
// comparator and one RAM read plus one write per cycle. Emission then reads the key, then the
// payload, then loads the output register for each row, and waits while the output side stalls.
// With order_mode 0, or with fewer than two rows, the sort is skipped. No clearing pass is
// needed after reset.
module sort_rows_by_w_coordinate
    import srw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input rows
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // u_coord, v_coord, w_coord
    input  logic                  i_s_tlast,   // last_row
    // Output rows
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // out_u, out_v, out_w, row_index
    output logic                  o_m_tlast,   // last_out
    output logic                  o_m_tuser,   // overflow
    // Configuration: order_mode
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_HOLD,
        ST_SCAN,
        ST_PUT,
        ST_EM_RD,
        ST_EM_UV,
        ST_EM_OUT
    } t_state;

    t_state                r_state;
    logic                  r_mode;
    logic [CNT_W-1:0]      r_count;
    logic                  r_dropped;
    logic [IDX_W-1:0]      r_p;
    logic [IDX_W-1:0]      r_q;
    logic [IDX_W-1:0]      r_k;
    t_key_row              r_pivot;
    logic [COORD_BITS-1:0] r_em_w;
    logic [IDX_W-1:0]      r_em_idx;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_u;
    logic [COORD_BITS-1:0] r_out_v;
    logic [COORD_BITS-1:0] r_out_w;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_last;
    logic                  r_out_ovf;

    // RAM ports
    logic                  key_we;
    logic [IDX_W-1:0]      key_waddr;
    t_key_row              key_wdata;
    logic [IDX_W-1:0]      key_raddr;
    t_key_row              key_rdata;
    logic                  uv_we;
    logic [IDX_W-1:0]      uv_raddr;
    logic [UV_W-1:0]       uv_rdata;

    // Control terms
    logic                  in_fire;
    logic                  row_fits;
    logic [CNT_W-1:0]      count_after;
    logic                  swap;
    logic                  q_is_last;
    logic                  p_is_done;
    logic                  k_is_last;
    logic                  out_free;
    logic [COORD_BITS-1:0] in_u;
    logic [COORD_BITS-1:0] in_v;
    logic [COORD_BITS-1:0] in_w;

    assign in_u = i_s_tdata[COORD_BITS-1:0];
    assign in_v = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_w = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];

    assign o_s_tready  = (r_state == ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_s_tvalid && o_s_tready;
    assign row_fits    = (r_count < CNT_W'(MAX_ROWS));
    assign count_after = row_fits ? (r_count + 1'b1) : r_count;

    assign swap      = ($signed(key_rdata.w) < $signed(r_pivot.w));
    assign q_is_last = ((CNT_W'(r_q) + 1'b1) == r_count);
    assign p_is_done = ((CNT_W'(r_p) + CNT_W'(2)) >= r_count);
    assign k_is_last = ((CNT_W'(r_k) + 1'b1) == r_count);
    assign out_free  = !r_out_valid || i_m_tready;

    // Steer key RAM write: load, swap during scan, or settle position p
    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_count[IDX_W-1:0];
        key_wdata = '{w: in_w, idx: r_count[IDX_W-1:0]};
        unique case (r_state)
            ST_LOAD: begin
                key_we = in_fire && row_fits;
            end
            ST_SCAN: begin
                key_we    = swap;
                key_waddr = r_q;
                key_wdata = r_pivot;
            end
            ST_PUT: begin
                key_we    = 1'b1;
                key_waddr = r_p;
                key_wdata = r_pivot;
            end
            default: begin
                key_we = 1'b0;
            end
        endcase
    end

    // Steer key RAM read address
    always_comb begin
        unique case (r_state)
            ST_FETCH: key_raddr = r_p;
            ST_HOLD:  key_raddr = IDX_W'(r_p + 1'b1);
            ST_SCAN:  key_raddr = IDX_W'(r_q + 1'b1);
            ST_PUT:   key_raddr = IDX_W'(r_p + 1'b1);
            default:  key_raddr = r_k;
        endcase
    end

    assign uv_we    = in_fire && row_fits;
    assign uv_raddr = (r_state == ST_EM_UV) ? key_rdata.idx : r_em_idx;

    srw_ram #(
        .WIDTH (KEY_ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    srw_ram #(
        .WIDTH (UV_W),
        .DEPTH (MAX_ROWS)
    ) u_uv_ram (
        .i_clk   (i_clk),
        .i_we    (uv_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({in_v, in_u}),
        .i_raddr (uv_raddr),
        .o_rdata (uv_rdata)
    );

    // Sequencer: load, exchange sort, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_p         <= '0;
            r_q         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            // Drop the output word once taken, unless the next one replaces it
            if (r_out_valid && i_m_tready && (r_state != ST_EM_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (in_fire) begin
                        r_count <= count_after;
                        if (!row_fits) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_p <= '0;
                            r_k <= '0;
                            if (r_mode && (count_after >= CNT_W'(2))) begin
                                r_state <= ST_FETCH;
                            end else begin
                                r_state <= ST_EM_RD;
                            end
                        end
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    r_pivot <= key_rdata;
                    r_q     <= IDX_W'(r_p + 1'b1);
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (swap) begin
                        r_pivot <= key_rdata;
                    end
                    if (q_is_last) begin
                        r_state <= ST_PUT;
                    end else begin
                        r_q <= IDX_W'(r_q + 1'b1);
                    end
                end
                ST_PUT: begin
                    if (p_is_done) begin
                        r_k     <= '0;
                        r_state <= ST_EM_RD;
                    end else begin
                        r_p     <= IDX_W'(r_p + 1'b1);
                        r_state <= ST_HOLD;
                    end
                end
                ST_EM_RD: begin
                    r_state <= ST_EM_UV;
                end
                ST_EM_UV: begin
                    r_em_w   <= key_rdata.w;
                    r_em_idx <= key_rdata.idx;
                    r_state  <= ST_EM_OUT;
                end
                ST_EM_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_u     <= uv_rdata[COORD_BITS-1:0];
                        r_out_v     <= uv_rdata[UV_W-1:COORD_BITS];
                        r_out_w     <= r_em_w;
                        r_out_idx   <= r_em_idx;
                        r_out_last  <= k_is_last;
                        r_out_ovf   <= r_dropped;
                        if (k_is_last) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                            r_state   <= ST_LOAD;
                        end else begin
                            r_k     <= IDX_W'(r_k + 1'b1);
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({ROW_IDX_W'(r_out_idx), r_out_w, r_out_v, r_out_u});
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;

    // Row count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ROWS))
        else $error("row count beyond store depth");

    // A dropped row implies a full store
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_count == CNT_W'(MAX_ROWS)))
        else $error("drop flag set with room left");

    // Scan position stays after the pivot and inside the stored rows
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_q > r_p) && (CNT_W'(r_q) < r_count)))
        else $error("scan index out of range");

    // Sorting only runs with at least two rows
    a_sort_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FETCH) || (r_state == ST_HOLD) || (r_state == ST_SCAN) ||
         (r_state == ST_PUT)) |-> (r_count >= CNT_W'(2)))
        else $error("sort running on fewer than two rows");

    // Sending the final row reopens the buffer empty
    a_close_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EM_OUT) && out_free && k_is_last) |=>
        ((r_state == ST_LOAD) && (r_count == '0) && !r_dropped && r_out_last))
        else $error("time step not closed after final row");

endmodule

@@ test/row_order_checker.sv @@
// Checker that predicts the w-sorter's output rows and compares them with the words it sends.
module row_order_checker
    import srw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input rows, watched only
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // u_coord, v_coord, w_coord
    input  logic                  i_s_tlast,   // last_row
    // Output rows, watched only
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // out_u, out_v, out_w, row_index
    input  logic                  i_m_tlast,   // last_out
    input  logic                  i_m_tuser,   // overflow
    // Configuration writes, watched only
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic                  i_cfg_data,
    // Status for the top
    output int                    o_fail_count,
    output int                    o_rows_due
);

    // One output row as the block should send it
    typedef struct {
        logic signed [COORD_BITS-1:0] u;
        logic signed [COORD_BITS-1:0] v;
        logic signed [COORD_BITS-1:0] w;
        logic [ROW_IDX_W-1:0]         idx;
        logic                         ovf;
        logic                         last;
    } t_out_row;

    // Rows of the time step being loaded
    logic signed [COORD_BITS-1:0] held_u   [MAX_ROWS];
    logic signed [COORD_BITS-1:0] held_v   [MAX_ROWS];
    logic signed [COORD_BITS-1:0] held_w   [MAX_ROWS];
    logic [ROW_IDX_W-1:0]         held_idx [MAX_ROWS];
    int                           held_count;
    logic                         rows_dropped;
    logic                         sort_by_w;

    t_out_row expected_rows [$];
    int       fail_count = 0;
    int       rows_due   = 0;

    assign o_fail_count = fail_count;
    assign o_rows_due   = rows_due;

    // Order the held rows of a closed time step and queue them
    task automatic queue_time_step();
        int       order [MAX_ROWS];
        int       tmp;
        t_out_row r;
        for (int k = 0; k < held_count; k++) order[k] = k;
        // exchange sort: swap only on a strictly smaller w further on
        if (sort_by_w) begin
            for (int p = 0; p < held_count; p++) begin
                for (int q = p + 1; q < held_count; q++) begin
                    if (held_w[order[q]] < held_w[order[p]]) begin
                        tmp      = order[p];
                        order[p] = order[q];
                        order[q] = tmp;
                    end
                end
            end
        end
        for (int k = 0; k < held_count; k++) begin
            r.u    = held_u[order[k]];
            r.v    = held_v[order[k]];
            r.w    = held_w[order[k]];
            r.idx  = held_idx[order[k]];
            r.ovf  = rows_dropped;
            r.last = (k == held_count - 1);
            expected_rows.insert(expected_rows.size(), r);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_row got;
        t_out_row want;
        if (!i_rst_n) begin
            held_count   = 0;
            rows_dropped = 1'b0;
            sort_by_w    = 1'b0;
            expected_rows.delete();
        end else begin
            // Compare each sent word with the oldest queued row
            if (i_m_tvalid && i_m_tready) begin
                got.u    = i_m_tdata[0 +: COORD_BITS];
                got.v    = i_m_tdata[COORD_BITS +: COORD_BITS];
                got.w    = i_m_tdata[2*COORD_BITS +: COORD_BITS];
                got.idx  = i_m_tdata[3*COORD_BITS +: ROW_IDX_W];
                got.ovf  = i_m_tuser;
                got.last = i_m_tlast;
                if (expected_rows.size() == 0) begin
                    fail_count++;
                    $display({"%0t: unexpected row: expected none, ",
                              "actual u=%h v=%h w=%h idx=%0d ovf=%b last=%b"},
                             $time, got.u, got.v, got.w, got.idx, got.ovf, got.last);
                end else begin
                    want = expected_rows.pop_front();
                    if (want.u !== got.u || want.v !== got.v || want.w !== got.w ||
                        want.idx !== got.idx || want.ovf !== got.ovf ||
                        want.last !== got.last) begin
                        fail_count++;
                        $display("%0t: row mismatch: expected u=%h v=%h w=%h idx=%0d ovf=%b last=%b",
                                 $time, want.u, want.v, want.w, want.idx, want.ovf, want.last);
                        $display("%0t:               actual u=%h v=%h w=%h idx=%0d ovf=%b last=%b",
                                 $time, got.u, got.v, got.w, got.idx, got.ovf, got.last);
                    end
                end
            end
            // Take a row in, or drop it when the store is full
            if (i_s_tvalid && i_s_tready) begin
                if (held_count < MAX_ROWS) begin
                    held_u[held_count]   = i_s_tdata[0 +: COORD_BITS];
                    held_v[held_count]   = i_s_tdata[COORD_BITS +: COORD_BITS];
                    held_w[held_count]   = i_s_tdata[2*COORD_BITS +: COORD_BITS];
                    held_idx[held_count] = held_count[ROW_IDX_W-1:0];
                    held_count++;
                end else begin
                    rows_dropped = 1'b1;
                end
                if (i_s_tlast) begin
                    queue_time_step();
                    held_count   = 0;
                    rows_dropped = 1'b0;
                end
            end
            // Track the ordering mode
            if (i_cfg_valid && i_cfg_ready) sort_by_w = i_cfg_data;
        end
        rows_due = expected_rows.size();
    end

endmodule

@@ test/tb.sv @@
// Top of the w-sorter testbench: clock, reset, row and mode stimulus, and the verdict.
module tb;
    import srw_pkg::*;

    // Ordering mode codes
    localparam logic ORDER_ARRIVAL = 1'b0;
    localparam logic ORDER_BY_W    = 1'b1;

    // Coordinate extremes
    localparam logic [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] C_ZERO = '0;
    localparam logic [COORD_BITS-1:0] C_NEG1 = '1;

    localparam int HOLD_CYCLES  = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ROWS   = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    int fail_count;
    int rows_due;
    int rows_sent   = 0;
    int src_gap_pct = 0;
    int dst_gap_pct = 0;
    bit hold_req    = 1'b0;

    sort_rows_by_w_coordinate DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    row_order_checker u_row_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_rows_due  (rows_due)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the block hangs
    initial begin
        #1600000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= dst_gap_pct);
        end
    end

    // Offer one row word, with random gaps before it; return at the next falling edge
    task automatic send_row(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v,
                            input logic [COORD_BITS-1:0] w, input logic last);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, v, u};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        rows_sent++;
    endtask

    // Drop valid and wait until every queued row has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (rows_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_order_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // w values: many near zero for ties, some extremes, the rest anywhere
    function automatic logic [COORD_BITS-1:0] pick_w();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return $urandom_range(0, 6) - 3;
        if (pick < 35) begin
            case ($urandom_range(0, 3))
                0:       return C_MAX;
                1:       return C_MIN;
                2:       return C_ZERO;
                default: return C_NEG1;
            endcase
        end
        return $urandom();
    endfunction

    // Mostly short time steps, a few full ones and a few that overflow
    function automatic int pick_step_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return $urandom_range(1, 6);
        if (pick < 90) return $urandom_range(7, 24);
        if (pick < 95) return MAX_ROWS;
        return $urandom_range(MAX_ROWS + 1, MAX_ROWS + 4);
    endfunction

    task automatic send_step(input int n_rows);
        for (int k = 0; k < n_rows; k++)
            send_row($urandom(), $urandom(), pick_w(), k == n_rows - 1);
    endtask

    // Random time steps in groups of four, switching mode between groups
    task automatic run_phase(input int src_pct, input int dst_pct, input bit with_hold);
        int stop_at;
        int steps;
        src_gap_pct = src_pct;
        dst_gap_pct = dst_pct;
        stop_at = rows_sent + PHASE_ROWS;
        steps = 0;
        while (rows_sent < stop_at) begin
            if (steps % 4 == 0) begin
                settle();
                write_order_mode(((steps / 4) % 2 == 0) ? ORDER_BY_W : ORDER_ARRIVAL);
                // hold the output so the next step backs up at the input
                if (with_hold && steps == 0) hold_req = 1'b1;
            end
            send_step(pick_step_len());
            steps++;
        end
    endtask

    // Stimulus
    initial begin
        logic [COORD_BITS-1:0] mixed_w [8];
        mixed_w = '{C_MAX, 5, C_MIN, 5, C_NEG1, C_ZERO, 5, 1};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = ORDER_ARRIVAL;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Arrival order from reset: one-row step, then coordinate extremes
        send_row(C_MAX, C_MIN, C_MIN, 1'b1);
        send_row(C_ZERO, C_NEG1, C_MAX, 1'b0);
        send_row(C_NEG1, C_ZERO, C_MIN, 1'b0);
        send_row(C_MIN, C_MAX, C_ZERO, 1'b0);
        send_row(32'h5A5A_A5A5, 32'hA5A5_5A5A, C_NEG1, 1'b1);

        // Sorted: one row, mixed w with ties, then all w equal
        settle();
        write_order_mode(ORDER_BY_W);
        send_row(1, 2, C_NEG1, 1'b1);
        for (int k = 0; k < 8; k++) send_row(k, ~k, mixed_w[k], k == 7);
        for (int k = 0; k < 6; k++) send_row(k + 100, k, 7, k == 5);

        // Random phases: sender mostly busy, then receiver mostly busy, then no idling
        run_phase(7, 49, 1'b0);
        run_phase(49, 7, 1'b0);
        run_phase(0, 0, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
